// File: hdl/hat_pkg.sv
// Package for the heap allocation tracker: event and status codes,
// sequencer states, table entry layout and the default table depth.
// No dependencies.
`default_nettype none

package hat_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  typedef enum logic [1:0] {
    MALLOC  = 2'd0,
    REALLOC = 2'd1,
    FREE    = 2'd2,
    OTHER   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_COLLISION       = 3'd1,
    ST_NULL_FREE       = 3'd2,
    ST_UNKNOWN_FREE    = 3'd3,
    ST_NULL_REALLOC    = 3'd4,
    ST_UNKNOWN_REALLOC = 3'd5,
    ST_FULL            = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_INSERT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] addr;
    logic [31:0] size;
  } entry_t;

endpackage

`default_nettype wire

// File: hdl/hat_if.sv
// Valid/ready channels of the heap allocation tracker: heap event requests
// in, result requests out. No dependencies.
`default_nettype none

interface hat_event_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] address;
  logic [63:0] old_address;
  logic [31:0] block_size;

  modport source (output valid, func, address, old_address, block_size, input ready);
  modport sink   (input valid, func, address, old_address, block_size, output ready);
endinterface

interface hat_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] alloc_count;
  logic [31:0] free_count;
  logic [31:0] realloc_count;
  logic [63:0] bytes_requested;
  logic [37:0] bytes_live;
  logic [6:0]  live_entries;

  modport source (output valid, status, alloc_count, free_count, realloc_count,
                  bytes_requested, bytes_live, live_entries, input ready);
  modport sink   (input valid, status, alloc_count, free_count, realloc_count,
                  bytes_requested, bytes_live, live_entries, output ready);
endinterface

`default_nettype wire

// File: hdl/heap_allocation_tracker.sv
// Heap allocation tracker: one heap event request in, one result request
// out. An allocate or a reallocate that inserts a block passes through the
// scan, insert and finish states before the next request. The entry memory
// has one read port, and the sequencer walks it one entry per cycle through
// a single subtract/compare unit. It then writes the block in the insert
// state, loads the result register in the finish state and goes back to
// idle. A free of a non-null address, a collision, a full table and an
// unknown reallocate skip the insert. Null and "other" events go straight
// from idle to finish. After reset a clearing pass marks every entry free;
// no request is taken meanwhile. A finished result sits in the output
// register, so the next request can be taken while it waits; only a result
// that is ready while the register is still occupied holds the sequencer
// until the sink takes it. Depends on hat_pkg and hat_if.
`default_nettype none

module heap_allocation_tracker #(
  parameter int TABLE_DEPTH = hat_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  hat_event_if.sink   ev,
  hat_result_if.source res
);
  import hat_pkg::*;

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int LIVE_W = (32 + CNT_W > 38) ? 32 + CNT_W : 39;
  localparam int CW_X   = (CNT_W > 7) ? CNT_W : 8;

  state_t state, state_next;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  entry_t           mem_wd;

  logic [CNT_W-1:0] k;
  logic             dv;
  logic [IDX_W-1:0] d_idx;

  func_t       op;
  logic [63:0] key;
  logic [63:0] ins_addr;
  logic [31:0] new_size;
  status_t     st;

  logic             coll, found, matched;
  logic [IDX_W-1:0] slot;
  logic             coll_next, found_next, matched_next;
  logic [IDX_W-1:0] slot_next;

  logic [31:0]       allocs_seen, frees_seen, reallocs_seen;
  logic [63:0]       requested_total;
  logic [LIVE_W-1:0] live_total;
  logic [CNT_W-1:0]  live_cnt;

  logic        out_valid;
  status_t     out_status;
  logic [31:0] out_allocs, out_frees, out_reallocs;
  logic [63:0] out_requested;
  logic [37:0] out_live;
  logic [6:0]  out_entries;

  logic        accept;
  logic        scan_last;
  logic        remove_hit;
  logic [64:0] diff;
  logic        borrow, eq, hit;
  logic [64:0] req_sum;
  logic [CW_X-1:0] cnt_x;
  logic        out_load;

  assign accept    = ev.valid && ev.ready;
  assign ev.ready  = (state == S_IDLE);
  assign scan_last = (k == CNT_W'(TABLE_DEPTH));
  assign out_load  = (state == S_FINISH) && (!out_valid || res.ready);

  // shared compare unit: key against the entry just read
  assign diff   = {1'b0, key} - {1'b0, rd_data.addr};
  assign borrow = diff[64];
  assign eq     = (diff[63:0] == 64'd0);
  assign hit    = !borrow && (diff[63:0] < {32'd0, rd_data.size});

  assign remove_hit = dv && (op != MALLOC) && rd_data.valid && eq;

  always_comb begin
    coll_next    = coll;
    found_next   = found;
    matched_next = matched;
    slot_next    = slot;
    if (dv) begin
      if (op == MALLOC) begin
        if (rd_data.valid && hit) coll_next = 1'b1;
        if (!rd_data.valid && !found) begin
          found_next = 1'b1;
          slot_next  = d_idx;
        end
      end else begin
        if (remove_hit) matched_next = 1'b1;
        // a slot freed by this removal is as good as an empty one
        if ((!rd_data.valid || remove_hit) && !found) begin
          found_next = 1'b1;
          slot_next  = d_idx;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (k == CNT_W'(TABLE_DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (func_t'(ev.func))
            MALLOC:  state_next = S_SCAN;
            FREE:    state_next = (ev.address == 64'd0) ? S_FINISH : S_SCAN;
            REALLOC: state_next = (ev.old_address == 64'd0) ? S_FINISH : S_SCAN;
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          case (op)
            MALLOC:  state_next = (coll_next || !found_next) ? S_FINISH : S_INSERT;
            REALLOC: state_next = matched_next ? S_INSERT : S_FINISH;
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_INSERT: state_next = S_FINISH;
      S_FINISH: begin
        if (!out_valid || res.ready) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  // entry memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = k[IDX_W-1:0];
    mem_wd = '0;
    case (state)
      S_CLEAR: mem_we = 1'b1;
      S_SCAN: begin
        if (remove_hit) begin
          mem_we = 1'b1;
          mem_wa = d_idx;
          mem_wd = '{valid: 1'b0, addr: rd_data.addr, size: rd_data.size};
        end
      end
      S_INSERT: begin
        mem_we = 1'b1;
        mem_wa = slot;
        mem_wd = '{valid: 1'b1, addr: ins_addr, size: new_size};
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[k[IDX_W-1:0]];
  end

  assign req_sum = {1'b0, requested_total} + {33'd0, ev.block_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      k               <= '0;
      dv              <= 1'b0;
      allocs_seen     <= '0;
      frees_seen      <= '0;
      reallocs_seen   <= '0;
      requested_total <= '0;
      live_total      <= '0;
      live_cnt        <= '0;
      out_valid       <= 1'b0;
    end else begin
      dv    <= (state == S_SCAN) && !scan_last;
      d_idx <= k[IDX_W-1:0];

      if (out_load)       out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;

      case (state)
        S_CLEAR: k <= k + CNT_W'(1);
        S_IDLE: begin
          k <= '0;
          if (accept) begin
            op       <= func_t'(ev.func);
            key      <= (func_t'(ev.func) == REALLOC) ? ev.old_address : ev.address;
            ins_addr <= ev.address;
            new_size <= ev.block_size;
            coll     <= 1'b0;
            found    <= 1'b0;
            matched  <= 1'b0;
            case (func_t'(ev.func))
              MALLOC: begin
                st <= ST_OK;
                if (allocs_seen != '1) allocs_seen <= allocs_seen + 32'd1;
              end
              FREE: begin
                if (frees_seen != '1) frees_seen <= frees_seen + 32'd1;
                st <= (ev.address == 64'd0) ? ST_NULL_FREE : ST_OK;
              end
              REALLOC: begin
                if (reallocs_seen != '1) reallocs_seen <= reallocs_seen + 32'd1;
                st <= (ev.old_address == 64'd0) ? ST_NULL_REALLOC : ST_OK;
              end
              default: st <= ST_OK;
            endcase
            if (func_t'(ev.func) == MALLOC || func_t'(ev.func) == REALLOC) begin
              requested_total <= req_sum[64] ? '1 : req_sum[63:0];
            end
          end
        end
        S_SCAN: begin
          if (!scan_last) k <= k + CNT_W'(1);
          coll    <= coll_next;
          found   <= found_next;
          matched <= matched_next;
          slot    <= slot_next;
          if (remove_hit) begin
            live_total <= live_total - {{(LIVE_W-32){1'b0}}, rd_data.size};
            live_cnt   <= live_cnt - CNT_W'(1);
          end
          if (scan_last) begin
            case (op)
              MALLOC: begin
                if (coll_next)        st <= ST_COLLISION;
                else if (!found_next) st <= ST_FULL;
              end
              FREE:    if (!matched_next) st <= ST_UNKNOWN_FREE;
              REALLOC: if (!matched_next) st <= ST_UNKNOWN_REALLOC;
              default: st <= ST_OK;
            endcase
          end
        end
        S_INSERT: begin
          live_total <= live_total + {{(LIVE_W-32){1'b0}}, new_size};
          live_cnt   <= live_cnt + CNT_W'(1);
        end
        S_FINISH: begin
          if (out_load) begin
            out_status    <= st;
            out_allocs    <= allocs_seen;
            out_frees     <= frees_seen;
            out_reallocs  <= reallocs_seen;
            out_requested <= requested_total;
            out_live      <= (|live_total[LIVE_W-1:38]) ? '1 : live_total[37:0];
            out_entries   <= (cnt_x > CW_X'(127)) ? 7'd127 : cnt_x[6:0];
          end
        end
        default: k <= '0;
      endcase
    end
  end

  assign cnt_x = CW_X'(live_cnt);

  assign res.valid           = out_valid;
  assign res.status          = out_status;
  assign res.alloc_count     = out_allocs;
  assign res.free_count      = out_frees;
  assign res.realloc_count   = out_reallocs;
  assign res.bytes_requested = out_requested;
  assign res.bytes_live      = out_live;
  assign res.live_entries    = out_entries;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    live_cnt <= CNT_W'(TABLE_DEPTH))
    else $error("live entry count above table depth");

  a_empty_no_bytes: assert property (@(posedge clk) disable iff (rst)
    (live_cnt == '0) |-> (live_total == '0))
    else $error("empty table with nonzero live bytes");

  a_insert_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_INSERT) |-> found)
    else $error("insert without a free slot");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !ev.ready)
    else $error("request taken while previous one in progress");

endmodule

`default_nettype wire
